/* src/spac_pkg.sv */
// ----------------------------------------------------------------------------
// spac_pkg
// Shared widths, defaults and types of the sparse active-pixel compaction core.
// ----------------------------------------------------------------------------
package spac_pkg;

	localparam int HEIGHT_DEF   = 32;
	localparam int WIDTH_DEF    = 32;
	localparam int CHANNELS_DEF = 1;
	localparam int SLOTS_DEF    = 20;

	localparam int CHAN_W  = 16;
	localparam int THR_W   = 15;
	localparam int SLOT_W  = 6;
	localparam int SCNT_W  = 7;
	localparam int COORD_W = 7;
	localparam int POS_W   = 6;

	typedef struct packed {
		logic [SLOT_W-1:0]        slot;
		logic signed [CHAN_W-1:0] feat_zero;
		logic signed [CHAN_W-1:0] feat_one;
		logic signed [CHAN_W-1:0] feat_two;
		logic signed [CHAN_W-1:0] feat_three;
		logic [COORD_W-1:0]       row;
		logic [COORD_W-1:0]       col;
		logic                     last_slot;
	} spac_res_t;

	typedef struct packed {
		logic pad_busy;
		logic first_pixel;
	} spac_stat_t;

endpackage

/* src/spac_ctrl.sv */
// ----------------------------------------------------------------------------
// spac_ctrl
// Pixel scan tracking, active test, slot allocation and end-of-frame padding.
// ----------------------------------------------------------------------------
module spac_ctrl #(
	parameter int HEIGHT   = spac_pkg::HEIGHT_DEF,
	parameter int WIDTH    = spac_pkg::WIDTH_DEF,
	parameter int CHANNELS = spac_pkg::CHANNELS_DEF,
	parameter int SLOTS    = spac_pkg::SLOTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [spac_pkg::THR_W-1:0]          threshold,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [spac_pkg::CHAN_W-1:0]  chan_zero,
	input  logic signed [spac_pkg::CHAN_W-1:0]  chan_one,
	input  logic signed [spac_pkg::CHAN_W-1:0]  chan_two,
	input  logic signed [spac_pkg::CHAN_W-1:0]  chan_three,
	input  logic                                frame_end,
	input  logic                                obuf_ready,
	output logic                                push,
	output spac_pkg::spac_res_t                 res,
	output spac_pkg::spac_stat_t                stat
);
	import spac_pkg::*;

	logic [POS_W-1:0]         row_q;
	logic [POS_W-1:0]         col_q;
	logic                     done_q;
	logic                     first_q;
	logic [SCNT_W-1:0]        slots_q;
	logic                     pad_q;
	logic [SLOT_W-1:0]        pad_slot_q;
	logic signed [CHAN_W-1:0] fp_one_q;
	logic signed [CHAN_W-1:0] fp_two_q;
	logic signed [CHAN_W-1:0] fp_three_q;

	logic                     take;
	logic                     above;
	logic                     hit;
	logic [SCNT_W-1:0]        slots_nx;
	logic                     col_wrap;
	logic                     scan_last;
	spac_res_t                pix_res;
	spac_res_t                pad_res;

	assign in_stall = pad_q | ~obuf_ready;
	assign take     = in_valid & ~in_stall;

	assign above    = chan_zero > $signed({1'b0, threshold});
	assign hit      = ~done_q & above & (slots_q < SCNT_W'(SLOTS));
	assign slots_nx = slots_q + SCNT_W'(hit);

	assign col_wrap  = col_q == POS_W'(WIDTH - 1);
	assign scan_last = col_wrap & (row_q == POS_W'(HEIGHT - 1));

	always_comb begin
		pix_res.slot       = slots_q[SLOT_W-1:0];
		pix_res.feat_zero  = chan_zero;
		pix_res.feat_one   = (CHANNELS > 1) ? chan_one : '0;
		pix_res.feat_two   = (CHANNELS > 2) ? chan_two : '0;
		pix_res.feat_three = (CHANNELS > 3) ? chan_three : '0;
		pix_res.row        = COORD_W'(row_q) + COORD_W'(1);
		pix_res.col        = COORD_W'(col_q) + COORD_W'(1);
		pix_res.last_slot  = slots_q == SCNT_W'(SLOTS - 1);

		// padding reuses channels 1..3 of the frame's first pixel
		pad_res.slot       = pad_slot_q;
		pad_res.feat_zero  = '0;
		pad_res.feat_one   = (CHANNELS > 1) ? fp_one_q : '0;
		pad_res.feat_two   = (CHANNELS > 2) ? fp_two_q : '0;
		pad_res.feat_three = (CHANNELS > 3) ? fp_three_q : '0;
		pad_res.row        = COORD_W'(1);
		pad_res.col        = COORD_W'(1);
		pad_res.last_slot  = pad_slot_q == SLOT_W'(SLOTS - 1);
	end

	assign push = pad_q ? obuf_ready : (take & hit);
	assign res  = pad_q ? pad_res : pix_res;

	assign stat.pad_busy    = pad_q;
	assign stat.first_pixel = first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			col_q      <= '0;
			done_q     <= 1'b0;
			first_q    <= 1'b1;
			slots_q    <= '0;
			pad_q      <= 1'b0;
			pad_slot_q <= '0;
		end else begin
			if (take) begin
				if (frame_end) begin
					row_q   <= '0;
					col_q   <= '0;
					done_q  <= 1'b0;
					first_q <= 1'b1;
					slots_q <= '0;
					if (slots_nx < SCNT_W'(SLOTS)) begin
						pad_q      <= 1'b1;
						pad_slot_q <= slots_nx[SLOT_W-1:0];
					end
				end else begin
					first_q <= 1'b0;
					slots_q <= slots_nx;
					// scan position saturates once the whole frame has been seen
					if (!done_q) begin
						if (scan_last) begin
							done_q <= 1'b1;
						end else if (col_wrap) begin
							col_q <= '0;
							row_q <= row_q + POS_W'(1);
						end else begin
							col_q <= col_q + POS_W'(1);
						end
					end
				end
			end
			if (pad_q && obuf_ready) begin
				if (pad_slot_q == SLOT_W'(SLOTS - 1)) begin
					pad_q <= 1'b0;
				end else begin
					pad_slot_q <= pad_slot_q + SLOT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && first_q) begin
			fp_one_q   <= chan_one;
			fp_two_q   <= chan_two;
			fp_three_q <= chan_three;
		end
	end

endmodule

/* src/spac_obuf.sv */
// ----------------------------------------------------------------------------
// spac_obuf
// Two-entry result buffer parting the scan logic from the output handshake.
// ----------------------------------------------------------------------------
module spac_obuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  spac_pkg::spac_res_t push_res,
	output logic                ready,
	output logic                out_valid,
	input  logic                out_stall,
	output spac_pkg::spac_res_t out_res
);
	import spac_pkg::*;

	spac_res_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign ready     = count_q != 2'd2;
	assign out_valid = count_q != 2'd0;
	assign pop       = out_valid & ~out_stall;
	assign out_res   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* src/sparse_active_pixel_compaction_core.sv */
// ----------------------------------------------------------------------------
// sparse_active_pixel_compaction_core
// Compacts the first SLOTS active pixels of a raster frame into sparse slots.
// ----------------------------------------------------------------------------
// One pixel request can be taken every clock while in_stall is low. A pixel
// whose channel 0 exceeds the threshold is written, with its 1-based row and
// column, to the next free slot. The result is registered in a two-entry
// buffer before it reaches the output. The input is stalled in any cycle in
// which both entries are full, so under a steady result stream output stall
// passes back to the input. On the frame_end pixel every unfilled slot is
// emitted as padding, one slot per clock while the output is not stalled. The
// input is stalled while the padding is emitted. Scan position is kept as row
// and column counters.
module sparse_active_pixel_compaction_core #(
	parameter int HEIGHT   = spac_pkg::HEIGHT_DEF,
	parameter int WIDTH    = spac_pkg::WIDTH_DEF,
	parameter int CHANNELS = spac_pkg::CHANNELS_DEF,
	parameter int SLOTS    = spac_pkg::SLOTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [spac_pkg::THR_W-1:0]          cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [spac_pkg::CHAN_W-1:0]  chan_zero,
	input  logic signed [spac_pkg::CHAN_W-1:0]  chan_one,
	input  logic signed [spac_pkg::CHAN_W-1:0]  chan_two,
	input  logic signed [spac_pkg::CHAN_W-1:0]  chan_three,
	input  logic                                frame_end,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [spac_pkg::SLOT_W-1:0]         slot,
	output logic signed [spac_pkg::CHAN_W-1:0]  feat_zero,
	output logic signed [spac_pkg::CHAN_W-1:0]  feat_one,
	output logic signed [spac_pkg::CHAN_W-1:0]  feat_two,
	output logic signed [spac_pkg::CHAN_W-1:0]  feat_three,
	output logic [spac_pkg::COORD_W-1:0]        row,
	output logic [spac_pkg::COORD_W-1:0]        col,
	output logic                                last_slot
);
	import spac_pkg::*;

	logic [THR_W-1:0] threshold_q;
	logic             obuf_ready;
	logic             push;
	spac_res_t        push_res;
	spac_res_t        out_res;
	spac_stat_t       stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
		end else if (cfg_wr_en) begin
			threshold_q <= cfg_wr_data;
		end
	end

	spac_ctrl #(
		.HEIGHT   (HEIGHT),
		.WIDTH    (WIDTH),
		.CHANNELS (CHANNELS),
		.SLOTS    (SLOTS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.threshold  (threshold_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.chan_zero  (chan_zero),
		.chan_one   (chan_one),
		.chan_two   (chan_two),
		.chan_three (chan_three),
		.frame_end  (frame_end),
		.obuf_ready (obuf_ready),
		.push       (push),
		.res        (push_res),
		.stat       (stat)
	);

	spac_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_res  (push_res),
		.ready     (obuf_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign slot       = out_res.slot;
	assign feat_zero  = out_res.feat_zero;
	assign feat_one   = out_res.feat_one;
	assign feat_two   = out_res.feat_two;
	assign feat_three = out_res.feat_three;
	assign row        = out_res.row;
	assign col        = out_res.col;
	assign last_slot  = out_res.last_slot;

	// no result is written into a full buffer
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> obuf_ready)
		else $error("result pushed into full output buffer");

	// the final slot always closes any padding burst
	a_last_ends_pad: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_res.last_slot) |=> !stat.pad_busy)
		else $error("padding continues after final slot");

	// padding is only produced with the scan position rewound to a new frame
	a_pad_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		stat.pad_busy |-> stat.first_pixel)
		else $error("padding while a frame is in progress");

endmodule
